@@ hdl/assert_macros.svh @@
// Assertion macros shared by the key state tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true at a clock edge out of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

@@ hdl/kstt_pkg.sv @@
// Types, codes and constants of the key state tracker.
`default_nettype none

package kstt_pkg;

  // Default geometry and widths.
  localparam int KEY_COUNT = 128;
  localparam int KEY_W     = 8;
  localparam int TIME_W    = 32;
  localparam int DLY_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_IVL = 2'd1;

  // Configuration reset values in milliseconds.
  localparam logic [DLY_W-1:0] INIT_DELAY_RST = 16'd500;
  localparam logic [DLY_W-1:0] REPEAT_IVL_RST = 16'd100;

  // Bit positions in a key flag word.
  localparam int FLAG_DOWN    = 0;
  localparam int FLAG_PRESSED = 1;
  localparam int FLAG_TYPED   = 2;
  localparam int FLAG_W       = 3;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [KEY_W-1:0]  key_code;
    logic [TIME_W-1:0] now_ms;
    logic              check_valid;
  } in_beat_t;

  typedef struct packed {
    logic is_down;
    logic was_pressed;
    logic was_typed;
    logic bad_key;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REL_WR,
    ST_TICK,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;
    logic press_wr;
    logic rel_rd;
    logic rel_wr;
    logic qry_rd;
    logic sweep_start;
    logic sweep_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic key_ok;
    logic sweep_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ hdl/key_state_typematic_tracker.sv @@
// Top level of the key state tracker with typematic repeat.
//
//   Channel  Ports                                   Direction
//   in       in_valid, in_ready, in_data             item beat in
//   out      out_valid, out_ready, out_data          result beat out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_wdata  register write in
//
// A result is loaded after the decode step for press and query, after a further write step for
// release (read-modify-write of the pending table) and after a sweep for a frame
// tick, which walks one pending entry per cycle and fills the visible table.
// The next item is accepted at the earliest in the cycle after a result is loaded.
// Reset is synchronous; entry valid bits make both tables read as zero at once.
// A result waiting in the output register holds the following item in its last step.
`default_nettype none

module key_state_typematic_tracker #(
  parameter int KEY_COUNT = kstt_pkg::KEY_COUNT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire kstt_pkg::in_beat_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output kstt_pkg::out_beat_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [kstt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kstt_pkg::DLY_W-1:0]     cfg_wdata
);

  kstt_pkg::cmd_t  cmd;
  kstt_pkg::stat_t stat;

  // Sequencing of each item.
  kstt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // Tables, arithmetic and result register.
  kstt_dp #(
    .KEY_COUNT (KEY_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

endmodule

`default_nettype wire

@@ hdl/kstt_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module kstt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/kstt_ctrl.sv @@
// Controller state machine of the key state tracker.
`default_nettype none
`include "assert_macros.svh"

module kstt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire kstt_pkg::stat_t stat_i,
  output kstt_pkg::cmd_t       cmd_o
);

  kstt_pkg::state_t state_r;
  kstt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kstt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kstt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = kstt_pkg::ST_DECODE;
        end
      end
      kstt_pkg::ST_DECODE: begin
        if (stat_i.op == kstt_pkg::OP_TICK) begin
          state_nxt = kstt_pkg::ST_TICK;
        end else if (stat_i.op == kstt_pkg::OP_RELEASE && stat_i.key_ok) begin
          state_nxt = kstt_pkg::ST_REL_WR;
        end else begin
          state_nxt = kstt_pkg::ST_FIN;
        end
      end
      kstt_pkg::ST_REL_WR: begin
        state_nxt = kstt_pkg::ST_FIN;
      end
      kstt_pkg::ST_TICK: begin
        if (stat_i.sweep_done) begin
          state_nxt = kstt_pkg::ST_FIN;
        end
      end
      kstt_pkg::ST_FIN: begin
        if (stat_i.out_free) begin
          state_nxt = kstt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kstt_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands issued in each state.
  always_comb begin
    cmd_o    = '0;
    in_ready = 1'b0;
    case (state_r)
      kstt_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd_o.cap = in_valid;
      end
      kstt_pkg::ST_DECODE: begin
        case (stat_i.op)
          kstt_pkg::OP_PRESS:   cmd_o.press_wr    = stat_i.key_ok;
          kstt_pkg::OP_RELEASE: cmd_o.rel_rd      = stat_i.key_ok;
          kstt_pkg::OP_TICK:    cmd_o.sweep_start = 1'b1;
          kstt_pkg::OP_QUERY:   cmd_o.qry_rd      = stat_i.key_ok;
          default: begin
          end
        endcase
      end
      kstt_pkg::ST_REL_WR: begin
        cmd_o.rel_wr = 1'b1;
      end
      kstt_pkg::ST_TICK: begin
        cmd_o.sweep_step = !stat_i.sweep_done;
      end
      kstt_pkg::ST_FIN: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

  // A result is only loaded into a free output register.
  `ASSERT_PROP(a_load_free, cmd_o.out_load |-> stat_i.out_free,
               "result loaded while output register busy")
  // A frame sweep ends only by finishing the item.
  `ASSERT_PROP(a_tick_exit,
               state_r == kstt_pkg::ST_TICK |=>
               (state_r == kstt_pkg::ST_TICK || state_r == kstt_pkg::ST_FIN),
               "frame sweep left to an unexpected state")

endmodule

`default_nettype wire

@@ hdl/kstt_dp.sv @@
// Datapath of the key state tracker: key tables, sweep counters and result register.
`default_nettype none
`include "assert_macros.svh"

module kstt_dp #(
  parameter int KEY_COUNT = kstt_pkg::KEY_COUNT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire kstt_pkg::in_beat_t                in_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [kstt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kstt_pkg::DLY_W-1:0]        cfg_wdata,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output kstt_pkg::out_beat_t                    out_data,
  input  wire kstt_pkg::cmd_t                    cmd_i,
  output kstt_pkg::stat_t                        stat_o
);

  localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CNT_W = $clog2(KEY_COUNT + 1);

  typedef struct packed {
    logic [kstt_pkg::TIME_W-1:0] deadline;
    logic [kstt_pkg::FLAG_W-1:0] flags;
  } pend_entry_t;

  localparam int PEND_W = $bits(pend_entry_t);

  kstt_pkg::in_beat_t          item_r;
  logic [kstt_pkg::DLY_W-1:0]  init_dly_r;
  logic [kstt_pkg::DLY_W-1:0]  rep_ivl_r;
  logic [KEY_COUNT-1:0]        pend_vld_r;
  logic [KEY_COUNT-1:0]        vis_vld_r;
  logic [CNT_W-1:0]            rd_idx_r;
  logic [IDX_W-1:0]            wr_idx_r;
  logic                        stg_vld_r;
  logic                        out_valid_r;
  kstt_pkg::out_beat_t         out_data_r;

  logic                        key_ok;
  logic [IDX_W-1:0]            key_idx;
  logic                        sweep_rd;

  logic                        pend_we;
  logic [IDX_W-1:0]            pend_waddr;
  pend_entry_t                 pend_wdata;
  logic                        pend_re;
  logic [IDX_W-1:0]            pend_raddr;
  logic [PEND_W-1:0]           pend_rdata;
  pend_entry_t                 pend_eff;
  logic [IDX_W-1:0]            eff_idx;

  logic                        vis_we;
  logic [kstt_pkg::FLAG_W-1:0] vis_rdata;

  logic [kstt_pkg::TIME_W-1:0] now_plus_init;
  logic [kstt_pkg::TIME_W-1:0] now_plus_rep;
  logic [kstt_pkg::TIME_W-1:0] dl_diff;
  logic                        dl_passed;
  logic                        repeat_hit;
  pend_entry_t                 tick_entry;
  pend_entry_t                 rel_entry;
  kstt_pkg::out_beat_t         res;
  logic                        out_free;

  // Decode of the captured item.
  assign key_ok   = {1'b0, item_r.key_code} < (kstt_pkg::KEY_W + 1)'(KEY_COUNT);
  assign key_idx  = item_r.key_code[IDX_W-1:0];
  assign sweep_rd = cmd_i.sweep_step && (rd_idx_r < CNT_W'(KEY_COUNT));

  // Item capture and configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd_i.cap) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_dly_r <= kstt_pkg::INIT_DELAY_RST;
      rep_ivl_r  <= kstt_pkg::REPEAT_IVL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kstt_pkg::CFG_INIT_DELAY: init_dly_r <= cfg_wdata;
        kstt_pkg::CFG_REPEAT_IVL: rep_ivl_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Pending entry as read, with never-written entries reading as zero.
  assign eff_idx  = stg_vld_r ? wr_idx_r : key_idx;
  assign pend_eff = pend_vld_r[eff_idx] ? pend_entry_t'(pend_rdata) : '0;

  // Deadline arithmetic: wrap-safe "strictly later" test and the re-armed times.
  assign now_plus_init = item_r.now_ms + {{(kstt_pkg::TIME_W - kstt_pkg::DLY_W){1'b0}}, init_dly_r};
  assign now_plus_rep  = item_r.now_ms + {{(kstt_pkg::TIME_W - kstt_pkg::DLY_W){1'b0}}, rep_ivl_r};
  assign dl_diff       = item_r.now_ms - pend_eff.deadline;
  assign dl_passed     = (dl_diff != '0) && !dl_diff[kstt_pkg::TIME_W-1];
  assign repeat_hit    = pend_eff.flags[kstt_pkg::FLAG_DOWN] && dl_passed;

  // New pending entry for a frame tick and for a release.
  always_comb begin
    tick_entry                                  = '0;
    tick_entry.flags[kstt_pkg::FLAG_DOWN]       = pend_eff.flags[kstt_pkg::FLAG_DOWN];
    tick_entry.flags[kstt_pkg::FLAG_TYPED]      = repeat_hit;
    tick_entry.deadline                         = repeat_hit ? now_plus_rep : pend_eff.deadline;
    rel_entry                                   = pend_eff;
    rel_entry.flags[kstt_pkg::FLAG_DOWN]        = 1'b0;
  end

  // Pending table port selection.
  always_comb begin
    pend_we    = 1'b0;
    pend_waddr = key_idx;
    pend_wdata = '0;
    pend_re    = 1'b0;
    pend_raddr = key_idx;
    if (cmd_i.press_wr) begin
      pend_we          = 1'b1;
      pend_wdata.flags = '1;
      pend_wdata.deadline = now_plus_init;
    end
    if (cmd_i.rel_rd) begin
      pend_re = 1'b1;
    end
    if (cmd_i.rel_wr) begin
      pend_we    = 1'b1;
      pend_wdata = rel_entry;
    end
    if (sweep_rd) begin
      pend_re    = 1'b1;
      pend_raddr = rd_idx_r[IDX_W-1:0];
    end
    if (cmd_i.sweep_step && stg_vld_r) begin
      pend_we    = 1'b1;
      pend_waddr = wr_idx_r;
      pend_wdata = tick_entry;
    end
  end

  // The visible table takes the old pending flags during a frame sweep.
  assign vis_we = cmd_i.sweep_step && stg_vld_r;

  kstt_ram #(
    .WIDTH (PEND_W),
    .DEPTH (KEY_COUNT)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (pend_re),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  kstt_ram #(
    .WIDTH (kstt_pkg::FLAG_W),
    .DEPTH (KEY_COUNT)
  ) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (wr_idx_r),
    .wdata (pend_eff.flags),
    .re    (cmd_i.qry_rd),
    .raddr (key_idx),
    .rdata (vis_rdata)
  );

  // Entry valid bits; reset makes every entry read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= '0;
      vis_vld_r  <= '0;
    end else begin
      if (pend_we) begin
        pend_vld_r[pend_waddr] <= 1'b1;
      end
      if (vis_we) begin
        vis_vld_r[wr_idx_r] <= 1'b1;
      end
    end
  end

  // Sweep counters: read index runs one entry ahead of the write stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      wr_idx_r  <= '0;
      stg_vld_r <= 1'b0;
    end else if (cmd_i.sweep_start) begin
      rd_idx_r  <= '0;
      stg_vld_r <= 1'b0;
    end else if (cmd_i.sweep_step) begin
      stg_vld_r <= sweep_rd;
      if (sweep_rd) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
        wr_idx_r <= rd_idx_r[IDX_W-1:0];
      end
    end
  end

  // Result of the finished item.
  always_comb begin
    res = '0;
    case (kstt_pkg::op_t'(item_r.opcode))
      kstt_pkg::OP_PRESS, kstt_pkg::OP_RELEASE: begin
        res.bad_key = !key_ok;
      end
      kstt_pkg::OP_QUERY: begin
        if (key_ok) begin
          if (vis_vld_r[key_idx]) begin
            res.is_down     = vis_rdata[kstt_pkg::FLAG_DOWN];
            res.was_pressed = vis_rdata[kstt_pkg::FLAG_PRESSED];
            res.was_typed   = vis_rdata[kstt_pkg::FLAG_TYPED];
          end
        end else begin
          res.bad_key = item_r.check_valid;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds one beat until it is taken.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.op         = kstt_pkg::op_t'(item_r.opcode);
    stat_o.key_ok     = key_ok;
    stat_o.sweep_done = (rd_idx_r == CNT_W'(KEY_COUNT)) && !stg_vld_r;
    stat_o.out_free   = out_free;
  end

  // The pending table is never read and written at the same entry in the same cycle.
  `ASSERT_NEVER(a_pend_clash, pend_we && pend_re && (pend_waddr == pend_raddr),
                "pending table read and write collide")
  // The sweep read index never runs past the table.
  `ASSERT_PROP(a_sweep_bound, rd_idx_r <= CNT_W'(KEY_COUNT),
               "sweep index beyond key count")

endmodule

`default_nettype wire
